[design/utf8ld_pkg.sv]
package utf8ld_pkg;

    localparam int CP_W  = 21;
    localparam int CNT_W = 3;

    localparam logic [CP_W-1:0] REPL_CHAR = 21'h00FFFD;

    // Decoder state carried from one byte to the next
    typedef struct packed {
        logic [CP_W-1:0] pv;
        logic [1:0]      need;
        logic [1:0]      held;
    } dec_state_t;

    // Results caused by one byte: cnt results, all but the final one are
    // replacement characters; cp/repl describe the final one.
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [CP_W-1:0]  cp;
        logic             repl;
        logic             eot;
    } dec_job_t;

endpackage

[design/utf8ld_decode.sv]
module utf8ld_decode import utf8ld_pkg::*; (
    input  logic [7:0] data_byte,
    input  logic       end_of_text,
    input  dec_state_t cur_state,
    output dec_state_t nxt_state,
    output dec_job_t   job
);

    logic             seq_open;
    logic             is_cont;
    logic [CNT_W-1:0] break_cnt;
    logic [CNT_W-1:0] eot_cnt;
    logic [CNT_W-1:0] main_cnt;
    logic             main_hit;
    logic [CP_W-1:0]  main_cp;
    logic             main_repl;
    logic             eot_flush;
    logic [CP_W-1:0]  pv_ext;
    dec_state_t       st;

    assign seq_open = (cur_state.need != 2'd0);
    assign is_cont  = (data_byte[7:6] == 2'b10);
    assign pv_ext   = {cur_state.pv[CP_W-7:0], data_byte[5:0]};

    always_comb begin
        st        = cur_state;
        main_hit  = 1'b0;
        main_cp   = {13'd0, data_byte};
        main_repl = 1'b0;
        break_cnt = '0;

        if (seq_open && is_cont) begin
            st.pv   = pv_ext;
            st.need = cur_state.need - 2'd1;
            st.held = cur_state.held + 2'd1;
            if (st.need == 2'd0) begin
                main_hit = 1'b1;
                main_cp  = pv_ext;
                st       = '0;
            end
        end else begin
            // A broken sequence gives one replacement for the lead and each held byte
            if (seq_open) begin
                break_cnt = {1'b0, cur_state.held} + 3'd1;
            end
            st = '0;
            if (data_byte < 8'h80) begin
                main_hit = 1'b1;
            end else if (data_byte inside {[8'hC0:8'hDF]}) begin
                st.pv   = {16'd0, data_byte[4:0]};
                st.need = 2'd1;
            end else if (data_byte inside {[8'hE0:8'hEF]}) begin
                st.pv   = {17'd0, data_byte[3:0]};
                st.need = 2'd2;
            end else if (data_byte inside {[8'hF0:8'hF7]}) begin
                st.pv   = {18'd0, data_byte[2:0]};
                st.need = 2'd3;
            end else begin
                main_hit  = 1'b1;
                main_cp   = REPL_CHAR;
                main_repl = 1'b1;
            end
        end

        // Close any sequence left open at the end of the text
        eot_flush = end_of_text && (st.need != 2'd0);
        eot_cnt   = eot_flush ? ({1'b0, st.held} + 3'd1) : '0;
        if (eot_flush) begin
            st = '0;
        end

        main_cnt  = main_hit ? 3'd1 : 3'd0;
        nxt_state = st;
        job.cnt   = break_cnt + main_cnt + eot_cnt;
        job.cp    = (main_hit && !eot_flush) ? main_cp : REPL_CHAR;
        job.repl  = (main_hit && !eot_flush) ? main_repl : 1'b1;
        job.eot   = end_of_text;
    end

endmodule

[design/utf8_lossy_decoder_core.sv]
// Lossy UTF-8 decoder: takes one byte per transaction (tlast marks the last
// byte of a text) and returns code points, with U+FFFD standing in for every
// malformed byte. A byte is decoded in the cycle it is accepted; its results
// are held in a job register and leave through an output register one per
// cycle while the output is not stalled. A byte that causes no result leaves
// the input ready, and one that causes one result lets the next byte in as
// that result is emitted, giving one byte per cycle; a byte that causes n
// results (up to four, when a broken sequence is flushed) holds the input
// until the single result emitter sends its last. Output backpressure
// stalls the input only once pending results and the output register are full.
module utf8_lossy_decoder_core import utf8ld_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]  m_axis_tuser,   // [0] is_replacement, [1] last_of_run
    output logic        m_axis_tlast    // text_done
);

    dec_state_t       state_reg, state_next;
    dec_job_t         dec_job;

    logic             job_valid_reg;
    logic [CNT_W-1:0] job_cnt_reg;
    logic [CP_W-1:0]  job_cp_reg;
    logic             job_repl_reg;
    logic             job_eot_reg;

    logic             out_valid_reg;
    logic [CP_W-1:0]  out_cp_reg;
    logic             out_repl_reg;
    logic             out_last_reg;
    logic             out_done_reg;

    logic             out_free;
    logic             emit;
    logic             job_done;
    logic             accept;
    logic             final_one;

    utf8ld_decode u_decode (
        .data_byte   (s_axis_tdata),
        .end_of_text (s_axis_tlast),
        .cur_state   (state_reg),
        .nxt_state   (state_next),
        .job         (dec_job)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign emit          = job_valid_reg && out_free;
    assign final_one     = (job_cnt_reg == 3'd1);
    assign job_done      = emit && final_one;
    assign s_axis_tready = !job_valid_reg || job_done;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            job_valid_reg <= 1'b0;
            job_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end

            // Load a new job or count down the one being emitted
            if (accept) begin
                job_valid_reg <= (dec_job.cnt != 3'd0);
                job_cnt_reg   <= dec_job.cnt;
            end else if (emit) begin
                job_valid_reg <= !final_one;
                job_cnt_reg   <= job_cnt_reg - 3'd1;
            end

            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            job_cp_reg   <= dec_job.cp;
            job_repl_reg <= dec_job.repl;
            job_eot_reg  <= dec_job.eot;
        end
        if (emit) begin
            out_cp_reg   <= final_one ? job_cp_reg : REPL_CHAR;
            out_repl_reg <= final_one ? job_repl_reg : 1'b1;
            out_last_reg <= final_one;
            out_done_reg <= final_one && job_eot_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_cp_reg};
    assign m_axis_tuser  = {out_last_reg, out_repl_reg};
    assign m_axis_tlast  = out_done_reg;

    a_job_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid_reg |-> (job_cnt_reg != 3'd0) && (job_cnt_reg <= 3'd4))
        else $error("pending job with bad result count");

    a_idle_no_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.need == 2'd0) |-> (state_reg.held == 2'd0))
        else $error("held bytes with no open sequence");

    a_inner_is_repl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[1]) |->
            (m_axis_tuser[0] && (m_axis_tdata[20:0] == REPL_CHAR) && !m_axis_tlast))
        else $error("non-final result is not a replacement");

    a_eot_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_axis_tlast) |=> (state_reg.need == 2'd0))
        else $error("sequence left open after end of text");

    a_done_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[1])
        else $error("text end flagged on a non-final result");

endmodule
